// ===== rtl/core/hws_pkg.sv =====
// Shared types and constants for the HTML whitespace squeezer.
`timescale 1ns / 1ps
`default_nettype none

package hws_pkg;

    // Byte history and counter limits
    localparam int HISTORY_DEPTH = 10;
    localparam int NEST_LIMIT    = 15;
    localparam int DEPTH_W       = $clog2(NEST_LIMIT + 1);
    localparam int SEEN_LIMIT    = HISTORY_DEPTH + 1;
    localparam int SEEN_W        = $clog2(SEEN_LIMIT + 1);

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_BEAUTIFY = 0;

    // Character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Maximum result bytes caused by one input byte
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_beat_t;

    // Result bytes of one input beat, oldest in slot 0
    typedef struct packed {
        logic [1:0]                   count;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/hws_scan.sv =====
// Tag tracking, whitespace squeezing state and per-byte result generation.
`timescale 1ns / 1ps
`default_nettype none

module hws_scan
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire hws_pkg::in_beat_t beat,
    input  wire logic            beautify,
    output hws_pkg::res_t        result
);

    localparam int DW = hws_pkg::DEPTH_W;
    localparam int SW = hws_pkg::SEEN_W;
    localparam int HD = hws_pkg::HISTORY_DEPTH;

    logic                 in_quotes_reg, in_quotes_next;
    logic [DW-1:0]        pre_depth_reg, pre_depth_next;
    logic [DW-1:0]        script_depth_reg, script_depth_next;
    logic [DW-1:0]        textarea_depth_reg, textarea_depth_next;
    logic                 blank_pending_reg, blank_pending_next;
    logic [1:0]           newline_count_reg, newline_count_next;
    logic [HD-1:0][7:0]   history_reg, history_next;
    logic [SW-1:0]        seen_reg, seen_next;

    function automatic logic [DW-1:0] raise(input logic [DW-1:0] d);
        raise = (d < DW'(hws_pkg::NEST_LIMIT)) ? d + DW'(1) : d;
    endfunction

    // Work out next state and result bytes for the incoming beat
    always_comb
    begin
        logic [7:0]      c;
        logic [10:1]     pres;
        logic [10:1][7:0] lo;
        logic [10:1][7:0] raw;
        logic            is_nl;
        logic            is_blank;
        logic            pre_w;
        logic            script_w;
        logic            textarea_w;

        c        = beat.in_byte;
        is_nl    = (c == hws_pkg::CH_LF) || (c == hws_pkg::CH_CR);
        is_blank = (c == hws_pkg::CH_SPACE) || (c == hws_pkg::CH_TAB);

        // Positions older than the first byte never match
        for (int k = 1; k <= 10; k++)
        begin
            pres[k] = (seen_reg >= SW'(k));
            raw[k]  = history_reg[k-1];
            lo[k]   = history_reg[k-1] | 8'h20;
        end

        pre_w = pres[3] && lo[3] == "p" && lo[2] == "r" && lo[1] == "e";
        script_w = pres[6] && lo[6] == "s" && lo[5] == "c" && lo[4] == "r"
                   && lo[3] == "i" && lo[2] == "p" && lo[1] == "t";
        textarea_w = pres[8] && lo[8] == "t" && lo[7] == "e" && lo[6] == "x"
                     && lo[5] == "t" && lo[4] == "a" && lo[3] == "r"
                     && lo[2] == "e" && lo[1] == "a";

        in_quotes_next      = in_quotes_reg;
        pre_depth_next      = pre_depth_reg;
        script_depth_next   = script_depth_reg;
        textarea_depth_next = textarea_depth_reg;
        blank_pending_next  = blank_pending_reg;
        newline_count_next  = newline_count_reg;

        // Raise script or textarea depth on an opening tag with attributes when its separator arrives
        if (!in_quotes_reg && (is_blank || is_nl))
        begin
            if (pres[9] && raw[9] == hws_pkg::CH_LT && textarea_w)
                textarea_depth_next = raise(textarea_depth_reg);
            else if (pres[7] && raw[7] == hws_pkg::CH_LT && script_w)
                script_depth_next = raise(script_depth_reg);
        end

        // Squeeze whitespace outside protected regions
        result.count = 2'd1;
        result.bytes = '0;
        result.bytes[0] = c;
        if (!in_quotes_reg && pre_depth_next == '0 && textarea_depth_next == '0
            && script_depth_next == '0)
        begin
            if (is_nl)
            begin
                result.count = 2'd0;
                if (newline_count_reg < 2'd2)
                    newline_count_next = newline_count_reg + 2'd1;
            end
            else if (is_blank)
            begin
                result.count = 2'd0;
                blank_pending_next = 1'b1;
            end
            else if (newline_count_reg != 2'd0)
            begin
                if (c != hws_pkg::CH_GT)
                begin
                    result.bytes[0] = hws_pkg::CH_LF;
                    if (beautify && newline_count_reg > 2'd1)
                    begin
                        result.bytes[1] = hws_pkg::CH_LF;
                        result.bytes[2] = c;
                        result.count    = 2'd3;
                    end
                    else
                    begin
                        result.bytes[1] = c;
                        result.count    = 2'd2;
                    end
                end
                newline_count_next = 2'd0;
                blank_pending_next = 1'b0;
            end
            else if (blank_pending_reg)
            begin
                blank_pending_next = 1'b0;
                if (c != hws_pkg::CH_GT)
                begin
                    result.bytes[0] = hws_pkg::CH_SPACE;
                    result.bytes[1] = c;
                    result.count    = 2'd2;
                end
            end
        end

        if (c == hws_pkg::CH_QUOTE)
            in_quotes_next = ~in_quotes_reg;

        // Track pre, script and textarea tags on a closing angle bracket
        if (!in_quotes_next && c == hws_pkg::CH_GT)
        begin
            if (pre_w)
            begin
                if (pres[4] && raw[4] == hws_pkg::CH_LT)
                    pre_depth_next = raise(pre_depth_next);
                else if (pre_depth_next != '0 && pres[5] && raw[4] == hws_pkg::CH_SLASH
                         && raw[5] == hws_pkg::CH_LT)
                    pre_depth_next = pre_depth_next - DW'(1);
            end
            if (script_w)
            begin
                if (pres[7] && raw[7] == hws_pkg::CH_LT)
                    script_depth_next = raise(script_depth_next);
                else if (script_depth_next != '0 && pres[8]
                         && raw[7] == hws_pkg::CH_SLASH && raw[8] == hws_pkg::CH_LT)
                    script_depth_next = script_depth_next - DW'(1);
            end
            if (textarea_w)
            begin
                if (pres[9] && raw[9] == hws_pkg::CH_LT)
                    textarea_depth_next = raise(textarea_depth_next);
                else if (textarea_depth_next != '0 && pres[10]
                         && raw[9] == hws_pkg::CH_SLASH && raw[10] == hws_pkg::CH_LT)
                    textarea_depth_next = textarea_depth_next - DW'(1);
            end
        end

        // Shift history, newest first
        history_next = {history_reg[HD-2:0], c};
        seen_next    = (seen_reg < SW'(hws_pkg::SEEN_LIMIT)) ? seen_reg + SW'(1) : seen_reg;

        // Drop everything after the final byte
        if (beat.last_in)
        begin
            in_quotes_next      = 1'b0;
            pre_depth_next      = '0;
            script_depth_next   = '0;
            textarea_depth_next = '0;
            blank_pending_next  = 1'b0;
            newline_count_next  = 2'd0;
            history_next        = '0;
            seen_next           = '0;
        end
    end

    // Hold state, advance on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg      <= 1'b0;
            pre_depth_reg      <= '0;
            script_depth_reg   <= '0;
            textarea_depth_reg <= '0;
            blank_pending_reg  <= 1'b0;
            newline_count_reg  <= 2'd0;
            history_reg        <= '0;
            seen_reg           <= '0;
        end
        else if (take)
        begin
            in_quotes_reg      <= in_quotes_next;
            pre_depth_reg      <= pre_depth_next;
            script_depth_reg   <= script_depth_next;
            textarea_depth_reg <= textarea_depth_next;
            blank_pending_reg  <= blank_pending_next;
            newline_count_reg  <= newline_count_next;
            history_reg        <= history_next;
            seen_reg           <= seen_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hws_obuf.sv =====
// Result buffer: holds up to three bytes of one input beat and drains them in order.
`timescale 1ns / 1ps
`default_nettype none

module hws_obuf
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire hws_pkg::res_t     result,
    output logic                   can_load,
    output logic                   dst_valid,
    input  wire logic              dst_ready,
    output hws_pkg::out_beat_t     dst_data
);

    localparam int MR = hws_pkg::MAX_RESULTS;

    logic [1:0]          rem_reg, rem_next;
    logic [MR-1:0][7:0]  buf_reg, buf_next;
    logic                pop;

    assign pop       = (rem_reg != 2'd0) && dst_ready;
    assign can_load  = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && dst_ready);
    assign dst_valid = (rem_reg != 2'd0);
    assign dst_data.out_byte = buf_reg[0];
    assign dst_data.run_last = (rem_reg == 2'd1);

    // Load a new beat's bytes or shift out the head
    always_comb
    begin
        rem_next = rem_reg;
        buf_next = buf_reg;
        if (load)
        begin
            rem_next = result.count;
            buf_next = result.bytes;
        end
        else if (pop)
        begin
            rem_next = rem_reg - 2'd1;
            buf_next = {8'h00, buf_reg[MR-1:1]};
        end
    end

    // Hold count under reset; payload needs none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= 2'd0;
        else
            rem_reg <= rem_next;
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/html_whitespace_squeezer_unit.sv =====
// Top level of the HTML whitespace squeezer: stream ports, config register, core wiring.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  src     | in        | src_valid / src_ready | in_byte, last_in
//  dst     | out       | dst_valid / dst_ready | out_byte, run_last
//  apb     | in / out  | psel, penable, pready | beautify at address 0
//
// One input beat is accepted per cycle while each byte yields at most one result and dst is ready.
// A beat that yields two or three bytes (pending space or newlines) holds src_ready
// low while the result buffer drains, one byte a cycle while dst is ready.
// Results appear on dst the cycle after acceptance; a stalled dst holds the buffer.
// Reset clears all scanning state and beautify; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module html_whitespace_squeezer_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          src_valid,
    output logic                               src_ready,
    input  wire hws_pkg::in_beat_t             src_data,
    output logic                               dst_valid,
    input  wire logic                          dst_ready,
    output hws_pkg::out_beat_t                 dst_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hws_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [hws_pkg::PDATA_W-1:0]   pwdata,
    output logic [hws_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    logic           beautify_reg;
    logic           take;
    logic           sel_beautify;
    hws_pkg::res_t  result;

    assign pready       = 1'b1;
    assign sel_beautify = (paddr[hws_pkg::PADDR_W-1:2] == 1'(hws_pkg::REG_BEAUTIFY));
    assign prdata       = sel_beautify ? {{(hws_pkg::PDATA_W-1){1'b0}}, beautify_reg} : '0;
    assign take         = src_valid && src_ready;

    // Write the beautify register on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            beautify_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && sel_beautify)
            beautify_reg <= pwdata[0];
    end

    hws_scan u_scan
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .beat     (src_data),
        .beautify (beautify_reg),
        .result   (result)
    );

    hws_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .result    (result),
        .can_load  (src_ready),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data)
    );

endmodule

`default_nettype wire

// ===== tb/html_whitespace_squeezer_unit_tb.sv =====
// Testbench for the HTML whitespace squeezer: directed and random text with a self-checking predictor.
`timescale 1ns / 1ps

module html_whitespace_squeezer_unit_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_GAP   = 8;
    localparam int PHASE_BYTES = 40;
    localparam logic [hws_pkg::PADDR_W-1:0] BEAUTIFY_ADDR =
        hws_pkg::PADDR_W'(4 * hws_pkg::REG_BEAUTIFY);

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         src_valid = 1'b0;
    logic                         src_ready;
    hws_pkg::in_beat_t            src_data = '0;
    logic                         dst_valid;
    logic                         dst_ready = 1'b0;
    hws_pkg::out_beat_t           dst_data;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [hws_pkg::PADDR_W-1:0]  paddr = '0;
    logic [hws_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [hws_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    // Stimulus and expected output stores
    hws_pkg::in_beat_t            feed_q [$];
    hws_pkg::out_beat_t           cleaned_q [$];
    logic [7:0]                   text_buf [$];
    int                           fed_total = 0;
    int                           err_count = 0;
    int                           src_idle_pct = 0;
    int                           dst_stall_pct = 0;
    logic                         in_took = 1'b0;
    logic                         out_took = 1'b0;

    // Predictor state
    logic                         beautify_on = 1'b0;
    logic                         quoted = 1'b0;
    logic [hws_pkg::DEPTH_W-1:0]  pre_lvl = '0;
    logic [hws_pkg::DEPTH_W-1:0]  script_lvl = '0;
    logic [hws_pkg::DEPTH_W-1:0]  textarea_lvl = '0;
    logic                         blank_held = 1'b0;
    logic [1:0]                   nl_held = '0;
    logic [7:0]                   hist [hws_pkg::HISTORY_DEPTH];
    logic [hws_pkg::SEEN_W-1:0]   hist_fill = '0;

    html_whitespace_squeezer_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < 40)
            $display("MISMATCH %s: got %0h, want %0h", what, got, want);
        err_count++;
    endtask

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Byte k positions back, or 9'h100 when the text is not that long yet
    function automatic logic [8:0] hist_at(int k);
        if (k < 1 || k > hws_pkg::HISTORY_DEPTH || k > int'(hist_fill))
            return 9'h100;
        return {1'b0, hist[k-1]};
    endfunction

    // Match a lowercase word ending at the newest byte, ignoring case
    function automatic bit ends_with(string w);
        int n;
        n = w.len();
        for (int i = 0; i < n; i++)
        begin
            if ((hist_at(n - i) | 9'h020) != {1'b0, w[i]})
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [hws_pkg::DEPTH_W-1:0] bump(logic [hws_pkg::DEPTH_W-1:0] d);
        return (d < hws_pkg::NEST_LIMIT) ? d + 1'b1 : d;
    endfunction

    function automatic void clear_scan();
        quoted       = 1'b0;
        pre_lvl      = '0;
        script_lvl   = '0;
        textarea_lvl = '0;
        blank_held   = 1'b0;
        nl_held      = '0;
        hist_fill    = '0;
        for (int i = 0; i < hws_pkg::HISTORY_DEPTH; i++)
            hist[i] = '0;
    endfunction

    // Work out the cleaned bytes caused by one input beat
    function automatic void squeeze_byte(hws_pkg::in_beat_t beat);
        logic [7:0]          c;
        logic [7:0]          outs [hws_pkg::MAX_RESULTS];
        int                  n;
        bit                  is_nl;
        bit                  is_bl;
        hws_pkg::out_beat_t  res;
        c     = beat.in_byte;
        n     = 0;
        is_nl = (c == hws_pkg::CH_LF) || (c == hws_pkg::CH_CR);
        is_bl = (c == hws_pkg::CH_SPACE) || (c == hws_pkg::CH_TAB);

        // Open tag with attributes: count it when the separator arrives
        if (!quoted && (is_nl || is_bl))
        begin
            if (hist_at(9) == hws_pkg::CH_LT && ends_with("textarea"))
                textarea_lvl = bump(textarea_lvl);
            else if (hist_at(7) == hws_pkg::CH_LT && ends_with("script"))
                script_lvl = bump(script_lvl);
        end

        // Squeeze outside quotes and protected regions, pass through inside
        if (!quoted && pre_lvl == 0 && textarea_lvl == 0 && script_lvl == 0)
        begin
            if (is_nl)
            begin
                if (nl_held < 2)
                    nl_held++;
            end
            else if (is_bl)
                blank_held = 1'b1;
            else
            begin
                if (nl_held != 0)
                begin
                    if (c != hws_pkg::CH_GT)
                    begin
                        outs[n++] = hws_pkg::CH_LF;
                        if (beautify_on && nl_held > 1)
                            outs[n++] = hws_pkg::CH_LF;
                    end
                    nl_held    = '0;
                    blank_held = 1'b0;
                end
                else if (blank_held)
                begin
                    blank_held = 1'b0;
                    if (c != hws_pkg::CH_GT)
                        outs[n++] = hws_pkg::CH_SPACE;
                end
                outs[n++] = c;
            end
        end
        else
            outs[n++] = c;

        if (c == hws_pkg::CH_QUOTE)
            quoted = ~quoted;

        // Track region nesting on tag close
        if (!quoted && c == hws_pkg::CH_GT)
        begin
            if (ends_with("pre"))
            begin
                if (hist_at(4) == hws_pkg::CH_LT)
                    pre_lvl = bump(pre_lvl);
                else if (pre_lvl != 0 && hist_at(4) == hws_pkg::CH_SLASH
                         && hist_at(5) == hws_pkg::CH_LT)
                    pre_lvl--;
            end
            if (ends_with("script"))
            begin
                if (hist_at(7) == hws_pkg::CH_LT)
                    script_lvl = bump(script_lvl);
                else if (script_lvl != 0 && hist_at(7) == hws_pkg::CH_SLASH
                         && hist_at(8) == hws_pkg::CH_LT)
                    script_lvl--;
            end
            if (ends_with("textarea"))
            begin
                if (hist_at(9) == hws_pkg::CH_LT)
                    textarea_lvl = bump(textarea_lvl);
                else if (textarea_lvl != 0 && hist_at(9) == hws_pkg::CH_SLASH
                         && hist_at(10) == hws_pkg::CH_LT)
                    textarea_lvl--;
            end
        end

        // Shift the history
        for (int i = hws_pkg::HISTORY_DEPTH - 1; i > 0; i--)
            hist[i] = hist[i-1];
        hist[0] = c;
        if (hist_fill < hws_pkg::SEEN_LIMIT)
            hist_fill++;

        if (beat.last_in)
            clear_scan();

        for (int k = 0; k < n; k++)
        begin
            res.out_byte = outs[k];
            res.run_last = (k == n - 1);
            cleaned_q.push_back(res);
        end
    endfunction

    // ---------------------------------------------------------------
    // Driver: feed source beats and toggle the sink stall
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!src_valid || in_took))
        begin
            if (feed_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                src_data  <= feed_q.pop_front();
                src_valid <= 1'b1;
            end
            else
                src_valid <= 1'b0;
        end
        dst_ready <= ($urandom_range(0, 99) >= dst_stall_pct);
    end

    // ---------------------------------------------------------------
    // Monitor: predict on accepted input, check accepted output
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        hws_pkg::out_beat_t want;
        if (!rst_n)
        begin
            in_took  <= 1'b0;
            out_took <= 1'b0;
        end
        else
        begin
            in_took  <= src_valid && src_ready;
            out_took <= dst_valid && dst_ready;
            if (psel && penable && pwrite && pready && paddr == BEAUTIFY_ADDR)
                beautify_on = pwdata[0];
            if (src_valid && src_ready)
                squeeze_byte(src_data);
            if (dst_valid && dst_ready)
            begin
                if (cleaned_q.size() == 0)
                    report("byte with nothing expected", 32'(dst_data.out_byte), 32'd0);
                else
                begin
                    want = cleaned_q.pop_front();
                    if (dst_data.out_byte !== want.out_byte)
                        report("out_byte", 32'(dst_data.out_byte), 32'(want.out_byte));
                    if (dst_data.run_last !== want.run_last)
                        report("run_last", 32'(dst_data.run_last), 32'(want.run_last));
                end
            end
        end
    end

    // Watchdog: end the run when outstanding work stops moving
    initial
    begin : watchdog
        int idle_edges;
        idle_edges = 0;
        while (idle_edges < STALL_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || in_took || out_took
                || (feed_q.size() == 0 && !src_valid && cleaned_q.size() == 0))
                idle_edges = 0;
            else
                idle_edges++;
        end
        $display("html_whitespace_squeezer_unit_tb: errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // Configuration access
    // ---------------------------------------------------------------
    task automatic reg_access(logic wr, logic [hws_pkg::PADDR_W-1:0] addr,
                              logic [hws_pkg::PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (!wr && prdata !== data)
            report("register read", prdata, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold until every expected byte has arrived and the block is quiet
    task automatic drain();
        while (feed_q.size() != 0 || src_valid || cleaned_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Text generation
    // ---------------------------------------------------------------
    task automatic add_str(string s, bit mix_case);
        logic [7:0] b;
        for (int i = 0; i < s.len(); i++)
        begin
            b = s[i];
            if (mix_case && ((b | 8'h20) >= "a") && ((b | 8'h20) <= "z")
                && $urandom_range(0, 1) == 1)
                b = b ^ 8'h20;
            text_buf.push_back(b);
        end
    endtask

    function automatic logic [7:0] ws_byte();
        case ($urandom_range(0, 3))
            0:       return hws_pkg::CH_SPACE;
            1:       return hws_pkg::CH_TAB;
            2:       return hws_pkg::CH_LF;
            default: return hws_pkg::CH_CR;
        endcase
    endfunction

    task automatic add_ws_run();
        repeat ($urandom_range(1, 4)) text_buf.push_back(ws_byte());
    endtask

    task automatic add_word();
        repeat ($urandom_range(1, 5))
        begin
            if ($urandom_range(0, 3) == 0)
                text_buf.push_back(8'($urandom_range("0", "9")));
            else
                text_buf.push_back(8'($urandom_range("a", "z") ^ ($urandom_range(0, 1) << 5)));
        end
    endtask

    function automatic string pick_tag(int idx);
        case (idx)
            0:       return "<pre>";
            1:       return "</pre>";
            2:       return "<script>";
            3:       return "</script>";
            4:       return "<textarea>";
            5:       return "</textarea>";
            6:       return "<b>";
            7:       return "</p>";
            8:       return "<scrip>";
            9:       return "</pr>";
            10:      return "< pre>";
            11:      return "<textare>";
            12:      return "</ script>";
            default: return "<pre";
        endcase
    endfunction

    task automatic add_segment();
        case ($urandom_range(0, 9))
            0, 1: add_str(pick_tag($urandom_range(0, 13)), 1'b1);
            2, 3: add_ws_run();
            4:    add_word();
            5:
            begin
                text_buf.push_back(hws_pkg::CH_QUOTE);
                add_word();
                add_ws_run();
                add_word();
                if ($urandom_range(0, 3) != 0)
                    text_buf.push_back(hws_pkg::CH_QUOTE);
            end
            6:
            begin
                if ($urandom_range(0, 1) == 1)
                    add_ws_run();
                text_buf.push_back(hws_pkg::CH_GT);
            end
            7:    text_buf.push_back(8'($urandom_range(0, 255)));
            8:
            begin
                if ($urandom_range(0, 1) == 1)
                    add_str("<script", 1'b1);
                else
                    add_str("<textarea", 1'b1);
                text_buf.push_back(ws_byte());
                add_str("a=1>", 1'b0);
            end
            default:
            begin
                add_word();
                add_ws_run();
                add_word();
            end
        endcase
    endtask

    // Queue the built text, marking its final byte
    task automatic flush_text();
        hws_pkg::in_beat_t beat;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            beat.in_byte = text_buf[i];
            beat.last_in = (i == text_buf.size() - 1);
            feed_q.push_back(beat);
        end
        fed_total += text_buf.size();
        text_buf.delete();
    endtask

    task automatic run_phase(int src_pct, int dst_pct, logic beauty, bit saturate);
        int goal;
        src_idle_pct  = src_pct;
        dst_stall_pct = dst_pct;
        reg_access(1'b1, BEAUTIFY_ADDR, {{(hws_pkg::PDATA_W-1){1'b0}}, beauty});
        reg_access(1'b0, BEAUTIFY_ADDR, {{(hws_pkg::PDATA_W-1){1'b0}}, beauty});
        goal = fed_total + PHASE_BYTES;
        // Drive the pre counter into saturation, then back down twice
        if (saturate)
        begin
            repeat (hws_pkg::NEST_LIMIT + 2) add_str("<pre>", 1'b1);
            add_str("  a \n\n b\t", 1'b0);
            repeat (2) add_str("</pre>", 1'b1);
            add_str("  c", 1'b0);
            flush_text();
        end
        while (fed_total < goal)
        begin
            repeat (($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12)) add_segment();
            flush_text();
        end
        drain();
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Register comes out of reset cleared
        reg_access(1'b0, BEAUTIFY_ADDR, '0);
        reg_access(1'b1, BEAUTIFY_ADDR, {{(hws_pkg::PDATA_W-1){1'b0}}, 1'b1});

        // Extreme bytes, squeezed blanks and newlines, quotes, drop before '>'
        text_buf.push_back(8'h00);
        text_buf.push_back(hws_pkg::CH_SPACE);
        text_buf.push_back(8'hFF);
        add_str("\n\r\n\"a  b\"\t> ", 1'b0);
        flush_text();
        // Tag match reaching before the start of the text
        add_str("pre>", 1'b0);
        flush_text();
        drain();

        run_phase(0, 0, 1'b0, 1'b0);
        run_phase(58, 0, 1'b1, 1'b0);
        run_phase(0, 58, 1'b0, 1'b0);
        run_phase(10, 10, 1'b1, 1'b1);

        repeat (20) @(negedge clk);
        if (err_count == 0 && cleaned_q.size() == 0)
            $display("html_whitespace_squeezer_unit_tb: clean");
        else
            $display("html_whitespace_squeezer_unit_tb: errors");
        $finish;
    end

endmodule
